[design/sem_pkg.sv]
// Shared types and constants for the Sobel edge magnitude block.
// Used by the front end, the back end and the top level; depends on nothing.
package sem_pkg;

  // Field widths of the configuration registers and the pixel stream.
  localparam int CFG_W   = 11;
  localparam int PIX_W   = 8;
  localparam int IDX_W   = 1;

  // Register indexes of the configuration port.
  localparam logic [IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [IDX_W-1:0] REG_HEIGHT = 1'b1;

  // Reset values and lower bounds of the frame geometry.
  localparam logic [CFG_W-1:0] GEOM_RESET = 11'd512;
  localparam logic [CFG_W-1:0] GEOM_MIN   = 11'd3;

  // Input kinds carried on tuser.
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Depths of the command queue and of the result queue.
  localparam int CMD_DEPTH = 4;
  localparam int OUT_DEPTH = 8;

  // One classified item, handed from the front end to the back end.
  typedef struct packed {
    logic             out_edge;   // emit the right-border result of the previous row
    logic             frame_end;  // that result closes the frame
    logic             shift;      // advance the window by one column
    logic             fill;       // first column of a row: replicate the column
    logic             use_pix;    // a real pixel row: use the sample and update the line stores
    logic             top_valid;  // the older line store holds a row above
    logic             emit;       // emit the result of the window after the shift
    logic [PIX_W-1:0] pix;
  } cmd_t;

endpackage

[design/sem_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module sem_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/sem_fifo.sv]
// Small register-based queue, first in first out.
// No dependencies; the caller never pushes when full nor pops when empty.
module sem_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    slots [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;

  assign full  = (count == CNTW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[design/sem_front.sv]
// Front end: configuration registers, raster counters and item classification.
// Depends on sem_pkg; pushes classified items into the command queue.
module sem_front
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  input  logic [IDX_W-1:0]                     cfg_index,
  input  logic [CFG_W-1:0]                     cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [PIX_W-1:0]                     s_tdata,
  input  logic                                 s_tuser,
  input  logic                                 q_full,
  output logic                                 q_push,
  output logic [$clog2(MAX_WIDTH)+$bits(cmd_t)-1:0] q_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int EW = (CFG_W > CW + 1) ? CFG_W : CW + 1;
  localparam int RW = CFG_W + 1;

  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [CW-1:0]    column_count;
  logic [RW-1:0]    row_count;
  logic [CW-1:0]    column_count_next;
  logic [RW-1:0]    row_count_next;

  logic [EW-1:0]    eff_w;
  logic [RW-1:0]    eff_h;
  logic [RW-1:0]    h_plus1;
  logic [CW-1:0]    c2;
  logic [RW-1:0]    r2;
  logic [RW-1:0]    r1;
  logic [CW:0]      c_inc;
  logic             wrap;
  logic             drop;
  logic             last_row;
  logic             accept;
  cmd_t             cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= GEOM_RESET;
      height_reg <= GEOM_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  width_reg  <= cfg_data;
        REG_HEIGHT: height_reg <= cfg_data;
      endcase
    end
  end

  // Clamp the geometry to what the line stores and the kernel support.
  always_comb begin
    if (width_reg < GEOM_MIN) begin
      eff_w = EW'(GEOM_MIN);
    end else if (EW'(width_reg) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_reg);
    end
    eff_h   = (height_reg < GEOM_MIN) ? RW'(GEOM_MIN) : RW'(height_reg);
    h_plus1 = eff_h + 1'b1;
  end

  always_comb begin
    // Wrap a stale column, then restart a frame whose row ran past the flush row.
    wrap = (EW'(column_count) >= eff_w);
    r1   = wrap ? row_count + 1'b1 : row_count;
    c2   = wrap ? '0 : column_count;
    r2   = r1;
    if (r1 > h_plus1) begin
      c2 = '0;
      r2 = '0;
    end

    drop     = (s_tuser == KIND_PIXEL) ? (r2 >= eff_h) : (r2 < eff_h);
    last_row = (r2 == h_plus1);

    cmd.out_edge  = (c2 == '0) && (r2 >= RW'(2));
    cmd.frame_end = last_row;
    cmd.shift     = !last_row && (r2 >= RW'(1));
    cmd.fill      = (c2 == '0);
    cmd.use_pix   = (r2 < eff_h);
    cmd.top_valid = (r2 >= RW'(2));
    cmd.emit      = !last_row && (c2 != '0) && (r2 >= RW'(1));
    cmd.pix       = s_tdata;

    // Advance the raster position; a dropped item keeps the wrapped position.
    c_inc = {1'b0, c2} + 1'b1;
    if (drop) begin
      column_count_next = c2;
      row_count_next    = r2;
    end else if (last_row) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (EW'(c_inc) >= eff_w) begin
      column_count_next = '0;
      row_count_next    = r2 + 1'b1;
    end else begin
      column_count_next = c_inc[CW-1:0];
      row_count_next    = r2;
    end
  end

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign q_push   = accept && !drop;
  assign q_data   = {c2, cmd};

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

[design/sem_back.sv]
// Back end: line stores, 3x3 window, Sobel kernels, magnitude pipeline, result queue.
// Depends on sem_pkg, sem_ram and sem_fifo; pops items from the command queue.
module sem_back
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      q_empty,
  input  logic [$clog2(MAX_WIDTH)+$bits(cmd_t)-1:0] q_data,
  output logic                                      q_pop,
  output logic                                      m_tvalid,
  input  logic                                      m_tready,
  output logic [PIX_W-1:0]                          m_tdata,
  output logic                                      m_tlast
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int CRW   = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  typedef struct packed {
    logic [16:0] v;
    logic [16:0] root;
  } sq_t;

  // One digit of the restoring square root.
  function automatic sq_t sq_step(sq_t x, logic [16:0] b);
    sq_t         y;
    logic [16:0] t;
    t = x.root + b;
    if (x.v >= t) begin
      y.v    = x.v - t;
      y.root = (x.root >> 1) + b;
    end else begin
      y.v    = x.v;
      y.root = x.root >> 1;
    end
    return y;
  endfunction

  function automatic logic [9:0] col_sum(col_t c);
    return {2'b00, c.top} + {1'b0, c.mid, 1'b0} + {2'b00, c.bot};
  endfunction

  function automatic logic [9:0] abs_diff(logic [9:0] a, logic [9:0] b);
    logic signed [10:0] d;
    d = $signed({1'b0, a}) - $signed({1'b0, b});
    return d[10] ? 10'(-d) : d[9:0];
  endfunction

  cmd_t            q_cmd;
  logic [CW-1:0]   q_addr;
  logic [CRW-1:0]  credit;
  logic            out_pop;
  logic            out_empty;
  logic [PIX_W:0]  out_head;

  // Stage 1: line store data and window update.
  logic            s1_vld;
  cmd_t            s1_cmd;
  logic [CW-1:0]   s1_addr;
  logic [PIX_W-1:0] rd_a;
  logic [PIX_W-1:0] rd_b;
  logic            mem_we;
  col_t            new_col;
  col_t            win [3];
  col_t            win_next [3];
  col_t            k_l, k_m, k_r;

  // Stage 2: kernel columns. Stage 3: absolute gradients. Stage 4: squares.
  logic            s2_vld, s3_vld, s4_vld, s5_vld, s6_vld;
  logic            s2_end, s3_end, s4_end, s5_end, s6_end;
  col_t            s2_l, s2_m, s2_r;
  logic [9:0]      s3_ax, s3_ay;
  logic [19:0]     s4_sqx, s4_sqy;
  logic [20:0]     sq_sum;
  logic            s5_sat, s6_sat;
  sq_t             s5_x, s6_x;
  sq_t             x5, x6;
  logic [PIX_W-1:0] magnitude;

  assign {q_addr, q_cmd} = q_data;

  // Pop only while the result queue has room for everything in flight.
  assign q_pop   = !q_empty && (credit < CRW'(OUT_DEPTH));
  assign out_pop = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
    end else begin
      credit <= credit + CRW'(q_pop && (q_cmd.out_edge || q_cmd.emit)) - CRW'(out_pop);
    end
  end

  assign mem_we = s1_vld && s1_cmd.use_pix;

  sem_ram #(.W(PIX_W), .DEPTH(MAX_WIDTH)) u_line_a (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_addr),
    .wdata (s1_cmd.pix),
    .re    (q_pop),
    .raddr (q_addr),
    .rdata (rd_a)
  );

  sem_ram #(.W(PIX_W), .DEPTH(MAX_WIDTH)) u_line_b (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1_addr),
    .wdata (rd_a),
    .re    (q_pop),
    .raddr (q_addr),
    .rdata (rd_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= q_pop;
    end
    if (q_pop) begin
      s1_cmd  <= q_cmd;
      s1_addr <= q_addr;
    end
  end

  always_comb begin
    new_col.mid = rd_a;
    new_col.top = s1_cmd.top_valid ? rd_b : rd_a;
    new_col.bot = s1_cmd.use_pix ? s1_cmd.pix : rd_a;
    win_next = win;
    if (s1_vld && s1_cmd.shift) begin
      if (s1_cmd.fill) begin
        win_next[0] = new_col;
        win_next[1] = new_col;
        win_next[2] = new_col;
      end else begin
        win_next[0] = win[1];
        win_next[1] = win[2];
        win_next[2] = new_col;
      end
    end
    // Right border of the previous row: clamp by repeating the last column.
    if (s1_cmd.out_edge) begin
      k_l = win[1];
      k_m = win[2];
      k_r = win[2];
    end else begin
      k_l = win_next[0];
      k_m = win_next[1];
      k_r = win_next[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win[0] <= '0;
      win[1] <= '0;
      win[2] <= '0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
    end else begin
      win    <= win_next;
      s2_vld <= s1_vld && (s1_cmd.out_edge || s1_cmd.emit);
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
    end
  end

  assign sq_sum = 21'(s4_sqx) + 21'(s4_sqy);

  always_comb begin
    x5 = s5_x;
    for (int i = 0; i < 4; i++) begin
      x5 = sq_step(x5, 17'(1) << (14 - 2 * i));
    end
    x6 = s6_x;
    for (int i = 0; i < 4; i++) begin
      x6 = sq_step(x6, 17'(1) << (6 - 2 * i));
    end
    magnitude = s6_sat ? {PIX_W{1'b1}} : x6.root[PIX_W-1:0];
  end

  always_ff @(posedge clk) begin
    s2_end <= s1_cmd.frame_end;
    s2_l   <= k_l;
    s2_m   <= k_m;
    s2_r   <= k_r;
    s3_end <= s2_end;
    s3_ax  <= abs_diff(col_sum(s2_r), col_sum(s2_l));
    s3_ay  <= abs_diff({2'b00, s2_l.bot} + {1'b0, s2_m.bot, 1'b0} + {2'b00, s2_r.bot},
                       {2'b00, s2_l.top} + {1'b0, s2_m.top, 1'b0} + {2'b00, s2_r.top});
    s4_end <= s3_end;
    s4_sqx <= 20'(s3_ax) * 20'(s3_ax);
    s4_sqy <= 20'(s3_ay) * 20'(s3_ay);
    s5_end <= s4_end;
    s5_sat <= |sq_sum[20:16];
    s5_x   <= '{v: {1'b0, sq_sum[15:0]}, root: '0};
    s6_end <= s5_end;
    s6_sat <= s5_sat;
    s6_x   <= x5;
  end

  sem_fifo #(.W(PIX_W + 1), .DEPTH(OUT_DEPTH)) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (s6_vld),
    .wdata ({s6_end, magnitude}),
    .pop   (out_pop),
    .rdata (out_head),
    .full  (),
    .empty (out_empty)
  );

  assign m_tvalid = !out_empty;
  assign m_tlast  = out_head[PIX_W];
  assign m_tdata  = out_head[PIX_W-1:0];

endmodule

[design/sobel_edge_magnitude.sv]
// Sobel edge magnitude over a raster pixel stream: one 8-bit pixel per
// transaction in, one 8-bit gradient magnitude per transaction out, with tlast
// on the result that closes the frame. The block sustains one input
// transaction per clock while the output side keeps up. A result passes the
// command queue, then the magnitude pipeline (line store read, window update,
// kernels, squaring, two square-root stages) and then the result queue.
// Results lag the pixels by one row and one pixel, so after the last pixel
// of a W x H frame send W+1 flush transactions (tuser high); the last one
// returns the final result with tlast set and restarts the raster counters.
// Borders are clamped to the edge. Pixels that arrive where only flushes are
// expected, and flushes that arrive before the frame is complete, are
// consumed and dropped. Write image_width (index 0) and image_height (index 1)
// only while the block is idle; widths are clamped to 3..MAX_WIDTH and
// heights to at least 3. The line stores need no clearing pass after reset.
//
// Depends on sem_pkg, sem_front, sem_fifo and sem_back.
module sobel_edge_magnitude
  import sem_pkg::*;
#(
  parameter int MAX_WIDTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  // Configuration write channel
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  // Pixel stream in
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [7:0]       s_tdata,   // [7:0] pixel
  input  logic             s_tuser,   // [0] kind: 0 pixel, 1 flush
  // Magnitude stream out
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,   // [7:0] magnitude
  output logic             m_tlast    // frame_end
);

  localparam int QW = $clog2(MAX_WIDTH) + $bits(cmd_t);

  logic          q_push;
  logic          q_pop;
  logic          q_full;
  logic          q_empty;
  logic [QW-1:0] q_wdata;
  logic [QW-1:0] q_rdata;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  // Classify each accepted transaction and track the raster position.
  sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  // Short command queue: lets the front keep accepting while the back waits.
  sem_fifo #(.W(QW), .DEPTH(CMD_DEPTH)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  // Line stores, window, kernels and magnitude; drives the output stream.
  sem_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

[design/sem_checker.sv]
// Port-level assertions for the Sobel edge magnitude block, with its bind.
// Depends on the top level sobel_edge_magnitude.
module sem_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed or dropped");

  // Reset empties the result queue.
  a_rst_no_out: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // Reset empties the command queue, so input is taken at once.
  a_rst_ready: assert property (@(posedge clk) rst |=> s_tready)
    else $error("input not ready right after reset");

endmodule

bind sobel_edge_magnitude sem_checker u_sem_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

[sim/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for sobel_edge_magnitude: a scoreboard class predicts each
// gradient magnitude from the accepted pixel stream, and plain tasks drive the
// streams and the configuration port. Depends on sem_pkg and the block's RTL.

localparam int LINE_DEPTH = 1024;

typedef struct {
  logic [7:0] mag;
  logic       last;
} edge_result_t;

class edge_scoreboard;
  logic [sem_pkg::CFG_W-1:0] width_reg;
  logic [sem_pkg::CFG_W-1:0] height_reg;
  logic [7:0]   line_a [LINE_DEPTH];   // newest row
  logic [7:0]   line_b [LINE_DEPTH];   // row above it
  logic [7:0]   win [3][3];            // [left, centre, right][top, mid, bottom]
  int           col;
  int           row;
  edge_result_t expected_q [$];
  int           errors;

  function new();
    width_reg  = sem_pkg::GEOM_RESET;
    height_reg = sem_pkg::GEOM_RESET;
    foreach (line_a[i]) begin
      line_a[i] = '0;
      line_b[i] = '0;
    end
    foreach (win[i, j]) win[i][j] = '0;
    col    = 0;
    row    = 0;
    errors = 0;
  endfunction

  function void set_reg(logic [sem_pkg::IDX_W-1:0] idx, logic [sem_pkg::CFG_W-1:0] val);
    if (idx == sem_pkg::REG_WIDTH) width_reg = val;
    else if (idx == sem_pkg::REG_HEIGHT) height_reg = val;
  endfunction

  function int eff_width();
    int w;
    w = int'(width_reg);
    if (w < int'(sem_pkg::GEOM_MIN)) w = int'(sem_pkg::GEOM_MIN);
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function int eff_height();
    int h;
    h = int'(height_reg);
    if (h < int'(sem_pkg::GEOM_MIN)) h = int'(sem_pkg::GEOM_MIN);
    return h;
  endfunction

  // Raster position the next transaction lands on: wrap a column past the
  // width, restart a frame whose row ran past the flush rows.
  function void position(output int c, output int r);
    c = col;
    r = row;
    if (c >= eff_width()) begin
      c = 0;
      r++;
    end
    if (r > eff_height() + 1) begin
      c = 0;
      r = 0;
    end
  endfunction

  function int pixels_left();
    int c, r;
    position(c, r);
    if (r >= eff_height()) return 0;
    return (eff_height() - r) * eff_width() - c;
  endfunction

  function int flushes_left();
    int c, r;
    position(c, r);
    if (r < eff_height()) return 0;
    return (eff_height() + 1 - r) * eff_width() - c + 1;
  endfunction

  // Sobel magnitude over three window columns, floor square root, clipped to 255.
  function logic [7:0] gradient(int lc, int mc, int rc);
    int          gx, gy;
    int unsigned sq, root, trial;
    gx = (int'(win[rc][0]) + 2 * int'(win[rc][1]) + int'(win[rc][2]))
       - (int'(win[lc][0]) + 2 * int'(win[lc][1]) + int'(win[lc][2]));
    gy = (int'(win[lc][2]) + 2 * int'(win[mc][2]) + int'(win[rc][2]))
       - (int'(win[lc][0]) + 2 * int'(win[mc][0]) + int'(win[rc][0]));
    sq   = unsigned'(gx * gx + gy * gy);
    root = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      if (trial * trial <= sq) root = trial;
    end
    return (root > 255) ? 8'd255 : root[7:0];
  endfunction

  function void expect_magnitude(logic [7:0] mag, logic last);
    edge_result_t item;
    item.mag  = mag;
    item.last = last;
    expected_q.push_back(item);
  endfunction

  // Advance the predicted raster state by one accepted transaction.
  function void note_input(logic kind, logic [7:0] pix);
    int         w, h, c, r;
    logic [7:0] top, mid, bot;
    w = eff_width();
    h = eff_height();
    position(c, r);
    col = c;
    row = r;
    // Drop pixels past the frame and flushes before it is complete.
    if (kind == sem_pkg::KIND_PIXEL && r >= h) return;
    if (kind == sem_pkg::KIND_FLUSH && r < h) return;
    // Right border of the previous row, with the right column replicated.
    if (c == 0 && r >= 2) expect_magnitude(gradient(1, 2, 2), r == h + 1);
    if (r == h + 1) begin
      col = 0;
      row = 0;
      return;
    end
    if (r >= 1) begin
      mid = line_a[c];
      bot = (r < h) ? pix : mid;
      top = (r >= 2) ? line_b[c] : mid;
      if (c == 0) begin
        for (int k = 0; k < 3; k++) begin
          win[k][0] = top;
          win[k][1] = mid;
          win[k][2] = bot;
        end
      end else begin
        win[0]    = win[1];
        win[1]    = win[2];
        win[2][0] = top;
        win[2][1] = mid;
        win[2][2] = bot;
      end
    end
    if (r < h) begin
      line_b[c] = line_a[c];
      line_a[c] = pix;
    end
    if (c >= 1 && r >= 1) expect_magnitude(gradient(0, 1, 2), 1'b0);
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    col = c;
    row = r;
  endfunction

  function void report_error(string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endfunction

  function void check_result(logic [7:0] mag, logic last);
    edge_result_t want;
    if (expected_q.size() == 0) begin
      report_error($sformatf("unexpected result magnitude=%0d last=%0b", mag, last));
      return;
    end
    want = expected_q.pop_front();
    if (mag !== want.mag || last !== want.last)
      report_error($sformatf("magnitude expected %0d got %0d, last expected %0b got %0b",
                             want.mag, mag, want.last, last));
  endfunction
endclass

module tb_top;
  import sem_pkg::*;

  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 24;    // several times the result latency
  localparam int RANDOM_ITEMS  = 700;

  typedef enum int {TEXTURE_NOISE, TEXTURE_SMOOTH, TEXTURE_BINARY} texture_e;
  typedef enum int {CUT_NONE, CUT_WIDTH, CUT_HEIGHT} cut_e;

  logic             clk;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             s_tvalid;
  logic             s_tready;
  logic [7:0]       s_tdata;   // [7:0] pixel
  logic             s_tuser;   // [0] kind
  logic             m_tvalid;
  logic             m_tready;
  logic [7:0]       m_tdata;   // [7:0] magnitude
  logic             m_tlast;   // frame end

  edge_scoreboard sb;
  bit             rst_done;
  bit             hold_req;     // ask the receiver for one long hold-off
  bit             rx_fast;      // receiver takes results with no stalls
  int             frame_items;  // pixels and flushes that count toward the run

  sobel_edge_magnitude #(.MAX_WIDTH(LINE_DEPTH)) uut (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Worst case is roughly 2.2k transactions, with random gaps and stalls on
  // both streams; past this timeout the block is declared hung.
  initial begin
    #10000000;
    $display("sobel_edge_magnitude: mismatch");
    $finish;
  end

  // Result side: stall a random number of cycles per transaction, with runs
  // of full throughput, and one long hold-off on request.
  initial begin
    int pause;
    int results;
    results = 0;
    m_tready <= 1'b0;
    while (!rst_done) @(posedge clk);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      pause = rx_fast ? 0 : $urandom_range(0, 15);
      if (pause > 0) begin
        m_tready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
      sb.check_result(m_tdata, m_tlast);
      results++;
      if (results % 64 == 0) rx_fast = ($urandom_range(0, 2) == 0);
    end
  end

  // Offer one transaction after a random gap and hold it until accepted.
  // Leave tvalid high afterwards so back-to-back items need no toggle.
  task automatic push_item(input logic kind, input logic [7:0] pix, input bit fast);
    int gap;
    gap = fast ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_input(kind, pix);
  endtask

  // Stop offering, wait for every predicted result, then let the pipeline
  // settle so that dropped transactions have left it too.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    if (!cfg_valid) cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  // mask[0] writes the width, mask[1] the height, in random order.
  task automatic write_geometry(input logic [1:0] mask, input logic [CFG_W-1:0] w,
                                input logic [CFG_W-1:0] h);
    bit h_first;
    h_first = 1'($urandom_range(0, 1));
    if (mask[1] && h_first) write_reg(REG_HEIGHT, h);
    if (mask[0]) write_reg(REG_WIDTH, w);
    if (mask[1] && !h_first) write_reg(REG_HEIGHT, h);
    cfg_valid <= 1'b0;
  endtask

  // Send one frame: pixels with a few early flushes mixed in, then flushes
  // with a few stray pixels. A cut shrinks the geometry part way through.
  task automatic run_frame(input texture_e style, input bit fast, input cut_e cut);
    int         cut_at, sent, base;
    logic [7:0] pix;
    base   = $urandom_range(0, 240);
    cut_at = (cut != CUT_NONE) ? int'($urandom_range(1, sb.pixels_left() - 1)) : -1;
    sent   = 0;
    while (sb.pixels_left() > 0) begin
      if (sent == cut_at) begin
        drain();
        if (cut == CUT_WIDTH)
          write_geometry(2'b01, CFG_W'($urandom_range(3, sb.eff_width() - 1)), '0);
        else
          write_geometry(2'b10, '0, CFG_W'($urandom_range(3, sb.eff_height() - 1)));
        if (sb.pixels_left() == 0) break;
      end
      if ($urandom_range(0, 39) == 0) push_item(KIND_FLUSH, 8'($urandom_range(0, 255)), fast);
      case (style)
        TEXTURE_NOISE:  pix = 8'($urandom_range(0, 255));
        TEXTURE_SMOOTH: pix = 8'(base + $urandom_range(0, 15));
        default:        pix = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
      push_item(KIND_PIXEL, pix, fast);
      sent++;
      frame_items++;
    end
    while (sb.flushes_left() > 0) begin
      if ($urandom_range(0, 19) == 0) push_item(KIND_PIXEL, 8'($urandom_range(0, 255)), fast);
      push_item(KIND_FLUSH, 8'($urandom_range(0, 255)), fast);
      frame_items++;
    end
  endtask

  initial begin
    logic [7:0]   img [9];
    int           frame_no;
    cut_e         cut;
    logic [1:0]   mask;
    int           w, h;
    img = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255};
    sb = new();
    rst       <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= KIND_PIXEL;
    hold_req  = 1'b0;
    rx_fast   = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    rst_done = 1'b1;

    // Smallest frame: flat, then hard edges, so magnitudes hit 0 and clip
    // at 255. Mix in an early flush and stray pixels after the frame.
    write_geometry(2'b11, 11'd3, 11'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 3) push_item(KIND_FLUSH, 8'hA5, 1'b0);
      push_item(KIND_PIXEL, img[i], 1'b0);
    end
    push_item(KIND_PIXEL, 8'h5A, 1'b0);
    for (int i = 0; i < 4; i++) begin
      push_item(KIND_FLUSH, 8'hFF, 1'b0);
      if (i == 1) push_item(KIND_PIXEL, 8'hFF, 1'b0);
    end

    // Random frames of small sizes; some shrink width or height mid-frame.
    frame_items = 0;
    frame_no    = 0;
    while (frame_items < RANDOM_ITEMS) begin
      cut = CUT_NONE;
      if (frame_no % 7 == 3) cut = CUT_WIDTH;
      else if (frame_no % 7 == 5) cut = CUT_HEIGHT;
      if (cut != CUT_NONE) begin
        w    = $urandom_range(6, 24);
        h    = $urandom_range(5, 8);
        mask = 2'b11;
      end else begin
        w    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 24);
        h    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        mask = 2'($urandom_range(1, 3));
      end
      drain();
      write_geometry(mask, CFG_W'(w), CFG_W'(h));
      run_frame(texture_e'($urandom_range(0, 2)), $urandom_range(0, 3) == 0, cut);
      frame_no++;
    end

    // Register extremes: the widest line with the shortest frame, then the
    // narrowest line with the tallest frame. Run the first past the full line
    // store and the second over twenty rows, then shrink the geometry to finish the frame.
    drain();
    write_geometry(2'b11, 11'h7FF, 11'h000);
    for (int i = 0; i < LINE_DEPTH + 40; i++) begin
      push_item(KIND_PIXEL, 8'($urandom_range(0, 255)), 1'b1);
    end
    drain();
    write_geometry(2'b01, 11'd20, '0);
    run_frame(TEXTURE_NOISE, 1'b1, CUT_NONE);
    drain();
    write_geometry(2'b11, 11'h000, 11'h7FF);
    for (int i = 0; i < 60; i++) begin
      push_item(KIND_PIXEL, 8'($urandom_range(0, 255)), 1'b1);
    end
    drain();
    write_geometry(2'b10, '0, 11'd24);
    run_frame(TEXTURE_SMOOTH, 1'b1, CUT_NONE);

    // Back-pressure: hold the result side while pixels stream at full rate,
    // so the block fills and stalls its input.
    drain();
    write_geometry(2'b11, 11'd16, 11'd8);
    hold_req = 1'b1;
    run_frame(TEXTURE_NOISE, 1'b1, CUT_NONE);

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("sobel_edge_magnitude: match");
    end else begin
      $display("sobel_edge_magnitude: mismatch");
    end
    $finish;
  end
endmodule
